// ===== rtl/ipf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_pkg
// Shared types for the integer predicate filter: modes, controller states and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ipf_pkg;

  typedef enum logic [1:0] {
    MODE_EVEN   = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_PRIME  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic REG_FILTER_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_ROOT,
    ST_CHECK,
    ST_TEST,
    ST_DIV,
    ST_DIVCHK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic root_step;
    logic div_init;
    logic div_step;
    logic d_inc;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_even;
    logic is_neg;
    logic is_small;
    logic cnt_zero;
    logic root_exact;
    logic d_over_root;
    logic rem_zero;
  } dp_status_t;

endpackage

// ===== rtl/ipf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_ctrl
// Sequencer for one word: classify, then the square root in square and prime modes, then trial division in prime mode.
// ----------------------------------------------------------------------------
module ipf_ctrl
  import ipf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  mode_t      filter_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_free,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        unique case (filter_mode)
          MODE_EVEN:   state_next = status.is_even ? ST_EMIT : ST_IDLE;
          MODE_SQUARE: state_next = status.is_neg ? ST_IDLE : ST_ROOT;
          MODE_PRIME:  state_next = (status.is_neg || status.is_small) ? ST_IDLE : ST_ROOT;
          default:     state_next = ST_IDLE;
        endcase
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.cnt_zero) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (filter_mode == MODE_SQUARE) begin
          state_next = status.root_exact ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.d_over_root) begin
          state_next = ST_EMIT;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.cnt_zero) begin
          state_next = ST_DIVCHK;
        end
      end
      ST_DIVCHK: begin
        if (status.rem_zero) begin
          state_next = ST_IDLE;
        end else begin
          cmd.d_inc  = 1'b1;
          state_next = ST_TEST;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/ipf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_dp
// Datapath: sample register, bit-serial square root, shift-subtract remainder
// unit and the trial divisor.
// ----------------------------------------------------------------------------
module ipf_dp
  import ipf_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  ctrl_cmd_t             cmd,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic [VALUE_BITS-1:0] value,
  output dp_status_t            status
);

  localparam int W  = VALUE_BITS;
  localparam int RB = (W + 1) / 2;
  localparam int CW = $clog2(W);

  logic [W-1:0]  rt_rem;
  logic [W-1:0]  rt_root;
  logic [W-1:0]  rt_bit;
  logic [CW-1:0] cnt;
  logic [RB:0]   divisor;
  logic [RB-1:0] dv_rem;
  logic [W-1:0]  dv_sh;

  logic [W:0]    rt_sum;
  logic          rt_ge;
  logic [RB:0]   dv_trial;
  logic          dv_ge;
  logic [RB:0]   dv_diff;

  assign rt_sum   = {1'b0, rt_root} + {1'b0, rt_bit};
  assign rt_ge    = {1'b0, rt_rem} >= rt_sum;
  assign dv_trial = {dv_rem, dv_sh[W-1]};
  assign dv_ge    = dv_trial >= divisor;
  assign dv_diff  = dv_trial - divisor;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value   <= in_value;
      rt_rem  <= in_value;
      rt_root <= '0;
      rt_bit  <= W'(1) << (2 * (RB - 1));
      cnt     <= CW'(RB - 1);
      divisor <= (RB + 1)'(2);
    end
    if (cmd.root_step) begin
      if (rt_ge) begin
        rt_rem  <= rt_rem - rt_sum[W-1:0];
        rt_root <= (rt_root >> 1) + rt_bit;
      end else begin
        rt_root <= rt_root >> 1;
      end
      rt_bit <= rt_bit >> 2;
      cnt    <= cnt - CW'(1);
    end
    if (cmd.div_init) begin
      dv_rem <= '0;
      dv_sh  <= value;
      cnt    <= CW'(W - 1);
    end
    if (cmd.div_step) begin
      dv_rem <= dv_ge ? dv_diff[RB-1:0] : dv_trial[RB-1:0];
      dv_sh  <= dv_sh << 1;
      cnt    <= cnt - CW'(1);
    end
    if (cmd.d_inc) begin
      divisor <= divisor + (RB + 1)'(1);
    end
  end

  always_comb begin
    status.is_even     = ~value[0];
    status.is_neg      = value[W-1];
    status.is_small    = (value[W-1:1] == '0);
    status.cnt_zero    = (cnt == '0);
    status.root_exact  = (rt_rem == '0);
    status.d_over_root = {{(W-RB-1){1'b0}}, divisor} > rt_root;
    status.rem_zero    = (dv_rem == '0);
  end

endmodule

// ===== rtl/integer_predicate_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_predicate_filter
// Passes on only the signed words that satisfy the predicate set by the
// filter_mode register: even, perfect square or prime; the unused mode passes none.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  sample_value
// m_*       out        m_tvalid/m_tready  kept_value
// apb       in/out     psel/penable       filter_mode at address 0
//
// A word in even or unused mode, or one that is negative or too small to test,
// is classified and then dropped, or emitted when an even word is kept. Otherwise
// the bit-serial square root runs first, and a kept square is then emitted. Prime
// mode then runs the one-bit-a-cycle remainder unit for each trial divisor from 2
// up to the square root, drops the word at the first divisor that divides it, and emits a kept prime.
// A kept word stalls the input only while the output register is still full.
// Reset clears the mode to even.
// ----------------------------------------------------------------------------
module integer_predicate_filter
  import ipf_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,  // Bits up from 0: sample_value.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata,  // Bits up from 0: kept_value.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  mode_t                 filter_mode;
  ctrl_cmd_t             cmd;
  dp_status_t            status;
  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] kept_value;
  logic                  out_free;

  assign pready   = 1'b1;
  assign out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_EVEN;
    end else if (psel && penable && pwrite && (paddr[2] == REG_FILTER_MODE)) begin
      filter_mode <= mode_t'(pwdata[1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FILTER_MODE) begin
      prdata[1:0] = filter_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kept_value <= value;
    end
  end

  always_comb begin
    m_tdata                   = '0;
    m_tdata[VALUE_BITS-1:0]   = kept_value;
  end

  ipf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .filter_mode (filter_mode),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .out_free    (out_free),
    .status      (status),
    .cmd         (cmd)
  );

  ipf_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_value (s_tdata[VALUE_BITS-1:0]),
    .value    (value),
    .status   (status)
  );

endmodule

// ===== tb/tb_integer_predicate_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_predicate_filter
// Streams signed words through the filter under every mode, predicts which
// words must pass and compares each passed word with the oldest prediction,
// while both stream sides idle and stall at random and the mode register is
// rewritten between phases over the APB port.
// ----------------------------------------------------------------------------
module tb_integer_predicate_filter;
  import ipf_pkg::*;

  localparam int VALUE_BITS = 16;
  localparam int DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
  localparam logic [2:0] ADDR_MODE = {REG_FILTER_MODE, 2'b00};
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam int DRAIN_CYCLES = 4000;
  localparam int RANDOM_PER_PHASE = 90;

  class filter_scoreboard;
    mode_t mode;
    logic [VALUE_BITS-1:0] pending_kept[$];
    int errors;
    int sample_count;
    int kept_count;

    function new();
      mode = MODE_EVEN;
      errors = 0;
      sample_count = 0;
      kept_count = 0;
    endfunction

    function bit passes_predicate(logic [VALUE_BITS-1:0] w);
      int v;
      int d;
      v = $signed(w);
      case (mode)
        MODE_EVEN: return !w[0];
        MODE_SQUARE: begin
          if (v < 0) return 0;
          d = 0;
          while ((d + 1) * (d + 1) <= v) d++;
          return d * d == v;
        end
        MODE_PRIME: begin
          if (v < 2) return 0;
          for (d = 2; d * d <= v; d++) begin
            if (v % d == 0) return 0;
          end
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    function void note_sample(logic [VALUE_BITS-1:0] w);
      sample_count++;
      if (passes_predicate(w)) pending_kept.push_back(w);
    endfunction

    function void check_word(logic [VALUE_BITS-1:0] w);
      logic [VALUE_BITS-1:0] want;
      kept_count++;
      if (pending_kept.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0d", $time, $signed(w));
        errors++;
        return;
      end
      want = pending_kept.pop_front();
      if (w !== want) begin
        $display("%0t: kept_value mismatch, expected %0d, actual %0d",
                 $time, $signed(want), $signed(w));
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [DATA_BITS-1:0] s_tdata;  // Bits up from 0: sample_value.
  logic m_tvalid;
  logic m_tready;
  logic [DATA_BITS-1:0] m_tdata;  // Bits up from 0: kept_value.
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  filter_scoreboard board;
  int send_idle;
  int recv_idle;
  int hold_left;

  integer_predicate_filter #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #120ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_word(m_tdata[VALUE_BITS-1:0]);
      if (s_tvalid && s_tready) board.note_sample(s_tdata[VALUE_BITS-1:0]);
    end
  end

  task automatic send_word(logic [VALUE_BITS-1:0] w);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DATA_BITS'(w);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending_kept.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(mode_t m);
    logic [31:0] rdata;
    wait_drained();
    apb_access(1'b1, ADDR_MODE, {30'($urandom_range(0, 32'h3fff_ffff)), m}, rdata);
    board.mode = m;
    // A write to an unmapped register must leave the mode alone.
    apb_access(1'b1, ADDR_UNUSED, $urandom, rdata);
    apb_access(1'b0, ADDR_MODE, 32'd0, rdata);
    if (rdata[1:0] !== m) begin
      $display("%0t: filter_mode readback mismatch, expected %0d, actual %0d",
               $time, m, rdata[1:0]);
      board.errors++;
    end
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_sample(mode_t m);
    int r;
    int root;
    r = $urandom_range(0, 99);
    case (m)
      MODE_SQUARE: begin
        root = $urandom_range(0, 181);
        if (r < 40) return VALUE_BITS'(root * root);
        if (r < 60) return VALUE_BITS'(root * root + $urandom_range(0, 2) - 1);
        return VALUE_BITS'($urandom);
      end
      MODE_PRIME: begin
        if (r < 40) return VALUE_BITS'($urandom_range(0, 400));
        if (r < 70) return VALUE_BITS'($urandom_range(2, 32767) | 1);
        return VALUE_BITS'($urandom);
      end
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  task automatic run_directed(mode_t m, int vals[$]);
    set_mode(m);
    foreach (vals[i]) send_word(VALUE_BITS'(vals[i]));
    s_tvalid <= 1'b0;
  endtask

  initial begin
    mode_t m;
    board = new();
    send_idle = 0;
    recv_idle = 0;
    hold_left = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    run_directed(MODE_EVEN, '{0, 1, -1, 32767, -32768, -2});
    run_directed(MODE_SQUARE, '{0, 1, 4, 32761, 32760, -4});
    run_directed(MODE_PRIME, '{2, 3, 4, 8, 9, 32749, 32761, -3, 1, 0});
    run_directed(MODE_NONE, '{2, 4, 0});

    for (int phase = 0; phase < 12; phase++) begin
      m = mode_t'(phase % 4);
      set_mode(m);
      case (phase / 4)
        0: begin send_idle = 38; recv_idle = 80; end
        1: begin send_idle = 80; recv_idle = 38; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (phase == 8) hold_left = 300;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 5 && i == RANDOM_PER_PHASE / 2) begin
          s_tvalid <= 1'b0;
          while (board.pending_kept.size() != 0) @(posedge clk);
        end
        send_word(pick_sample(m));
      end
      s_tvalid <= 1'b0;
    end

    wait_drained();
    $display("Sent %0d words through all four modes, %0d words passed the filter.",
             board.sample_count, board.kept_count);
    $display("Mode writes carried noise in the upper bits and unmapped writes were mixed in.");
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== integer_predicate_filter.f =====
rtl/ipf_pkg.sv
rtl/ipf_ctrl.sv
rtl/ipf_dp.sv
rtl/integer_predicate_filter.sv
tb/tb_integer_predicate_filter.sv
